/* sv/gic_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO interrupt controller package
// Request codes, register indexes, pin mode codes and shared types.
// ----------------------------------------------------------------------------
package gic_pkg;

	localparam int WORD_W   = 32;
	localparam int NUM_MODE = 4;

	// Bus request codes.
	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	// Word register indexes.
	localparam logic [2:0] REG_MODE0    = 3'd0;
	localparam logic [2:0] REG_MODE1    = 3'd1;
	localparam logic [2:0] REG_MODE2    = 3'd2;
	localparam logic [2:0] REG_MODE3    = 3'd3;
	localparam logic [2:0] REG_ENABLE   = 3'd4;
	localparam logic [2:0] REG_PENDING  = 3'd5;
	localparam logic [2:0] REG_DEBOUNCE = 3'd6;

	// Pin mode nibble codes; all other codes never detect.
	localparam logic [3:0] MODE_RISE = 4'd0;
	localparam logic [3:0] MODE_FALL = 4'd1;
	localparam logic [3:0] MODE_HIGH = 4'd2;
	localparam logic [3:0] MODE_LOW  = 4'd3;
	localparam logic [3:0] MODE_BOTH = 4'd4;

	// One item held in the input register.
	typedef struct packed {
		logic [1:0]        req_type;
		logic [2:0]        reg_index;
		logic [WORD_W-1:0] write_data;
		logic [WORD_W-1:0] pin_levels;
	} item_t;

	// Register state that the detector needs.
	typedef struct packed {
		logic [NUM_MODE-1:0][WORD_W-1:0] mode;
		logic [WORD_W-1:0]               enable;
		logic [WORD_W-1:0]               last_levels;
	} det_state_t;

endpackage

/* sv/gic_detect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO interrupt controller pin detector
// Matches every pin against its mode nibble and returns the enabled hits.
// ----------------------------------------------------------------------------
module gic_detect import gic_pkg::*; #(
	parameter int NUM_PINS = 32
) (
	input  det_state_t        st,
	input  logic [WORD_W-1:0] pin_levels,
	output logic [WORD_W-1:0] hits
);

	logic [WORD_W-1:0] raw_hits;

	// One independent match per pin; pins beyond the configured count stay quiet.
	for (genvar p = 0; p < WORD_W; p++) begin : g_pin
		logic [3:0] nib;
		logic       cur;
		logic       old;

		assign nib = st.mode[p / 8][(p % 8) * 4 +: 4];
		assign cur = pin_levels[p];
		assign old = st.last_levels[p];

		if (p < NUM_PINS) begin : g_used
			always_comb begin
				case (nib)
					MODE_RISE: raw_hits[p] = !old && cur;
					MODE_FALL: raw_hits[p] = old && !cur;
					MODE_HIGH: raw_hits[p] = cur;
					MODE_LOW:  raw_hits[p] = !cur;
					MODE_BOTH: raw_hits[p] = old ^ cur;
					default:   raw_hits[p] = 1'b0;
				endcase
			end
		end else begin : g_unused
			assign raw_hits[p] = 1'b0;
		end
	end

	assign hits = raw_hits & st.enable;

endmodule

/* sv/gic_regfile.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO interrupt controller register file
// Holds mode, enable, pending, debounce and last level words, and applies
// one item per cycle while fire is high.
// ----------------------------------------------------------------------------
module gic_regfile import gic_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  item_t             item,
	input  logic [WORD_W-1:0] hits,
	output det_state_t        st,
	output logic [WORD_W-1:0] rd_value,
	output logic              irq_next
);

	logic [NUM_MODE-1:0][WORD_W-1:0] mode_q;
	logic [WORD_W-1:0]               enable_q;
	logic [WORD_W-1:0]               pending_q;
	logic [WORD_W-1:0]               debounce_q;
	logic [WORD_W-1:0]               last_q;

	logic              is_write;
	logic [WORD_W-1:0] clear_bits;
	logic [WORD_W-1:0] enable_next;
	logic [WORD_W-1:0] pending_next;

	assign st.mode        = mode_q;
	assign st.enable      = enable_q;
	assign st.last_levels = last_q;

	assign is_write = item.req_type == REQ_WRITE;

	// Read decode returns the value before this item's updates.
	always_comb begin
		unique case (item.reg_index)
			REG_MODE0, REG_MODE1, REG_MODE2, REG_MODE3:
				rd_value = mode_q[item.reg_index[1:0]];
			REG_ENABLE:   rd_value = enable_q;
			REG_PENDING:  rd_value = pending_q;
			REG_DEBOUNCE: rd_value = debounce_q;
			default:      rd_value = '0;
		endcase
	end

	// Next enable and pending words; a detection wins over a clear.
	always_comb begin
		clear_bits  = '0;
		enable_next = enable_q;
		if (is_write && item.reg_index == REG_PENDING) begin
			clear_bits = item.write_data;
		end
		if (is_write && item.reg_index == REG_ENABLE) begin
			enable_next = item.write_data;
		end
		pending_next = (pending_q & ~clear_bits) | hits;
	end

	assign irq_next = |(pending_next & enable_next);

	// State update for each item that is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= '0;
			enable_q   <= '0;
			pending_q  <= '0;
			debounce_q <= '0;
			last_q     <= '0;
		end else if (fire) begin
			pending_q <= pending_next;
			enable_q  <= enable_next;
			last_q    <= item.pin_levels;
			if (is_write) begin
				unique case (item.reg_index)
					REG_MODE0, REG_MODE1, REG_MODE2, REG_MODE3:
						mode_q[item.reg_index[1:0]] <= item.write_data;
					REG_DEBOUNCE: debounce_q <= item.write_data;
					default: ;
				endcase
			end
		end
	end

endmodule

/* sv/gpio_interrupt_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO interrupt controller top level
// Input register, pin detection, register file and output register.
// ----------------------------------------------------------------------------
// The controller takes one item per clock cycle while in_stall is low and
// returns one result item for each, in order. An accepted item moves from
// the input register into the output register and is taken from the result
// ports when the output side is not stalled. Every item samples all pin
// levels and may read or write one word register. The detection and register
// update run combinationally between the input register and the output
// register, so the rate is set by that one stage. An item waiting in the
// input register moves on whenever the output register is empty or its item
// is taken in the same cycle, so in_stall only rises while a finished result
// is being held back by out_stall.
module gpio_interrupt_controller_top import gic_pkg::*; #(
	parameter int NUM_PINS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [2:0]        reg_index,
	input  logic [WORD_W-1:0] write_data,
	input  logic [WORD_W-1:0] pin_levels,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] read_data,
	output logic              irq_out
);

	item_t             item_s1;
	logic              valid_s1;
	logic              advance;
	det_state_t        st;
	logic [WORD_W-1:0] hits;
	logic [WORD_W-1:0] rd_value;
	logic              irq_next;
	logic              out_valid_q;
	logic [WORD_W-1:0] read_data_q;
	logic              irq_q;

	// The held item moves on when the output register is free this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= '{req_type, reg_index, write_data, pin_levels};
		end
	end

	gic_detect #(
		.NUM_PINS(NUM_PINS)
	) u_detect (
		.st        (st),
		.pin_levels(item_s1.pin_levels),
		.hits      (hits)
	);

	gic_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.item    (item_s1),
		.hits    (hits),
		.st      (st),
		.rd_value(rd_value),
		.irq_next(irq_next)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= (item_s1.req_type == REQ_READ) ? rd_value : '0;
			irq_q       <= irq_next;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign irq_out   = irq_q;

endmodule

/* sv/gic_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO interrupt controller checker
// Port level checks on flow control and latency, bound to the top level.
// ----------------------------------------------------------------------------
module gic_checker import gic_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [WORD_W-1:0] read_data,
	input logic              irq_out
);

	// The input side only waits while a result is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall raised without a stalled result");

	// An accepted item is followed by a valid result, possibly an older held one.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##2 out_valid)
		else $error("accepted item did not reach the output");

	// A stalled result keeps its valid and payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(read_data) && $stable(irq_out)))
		else $error("stalled result changed");

endmodule

bind gpio_interrupt_controller_top gic_checker u_gic_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.read_data(read_data),
	.irq_out  (irq_out)
);

/* test/gpio_interrupt_controller_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO interrupt controller testbench
// Drives pin samples and bus accesses into the controller and predicts every
// read value and irq level from a behavioral copy of the register state.
// Directed tests come first, then random traffic with idle and stall bursts,
// a long output hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
module gpio_interrupt_controller_top_tb;
	import gic_pkg::*;

	localparam int PINS      = 32;
	localparam int CYC_LIMIT = 200000;
	localparam int HOLD_LEN  = 60;
	localparam int MAX_SHOWN = 10;

	// Codes the block accepts but does not use.
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	// One expected result item.
	typedef struct {
		logic [WORD_W-1:0] rd;
		logic              irq;
	} gpio_result_t;

	logic              clk;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic [1:0]        req_type   = REQ_NONE;
	logic [2:0]        reg_index  = REG_MODE0;
	logic [WORD_W-1:0] write_data = '0;
	logic [WORD_W-1:0] pin_levels = '0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic [WORD_W-1:0] read_data;
	logic              irq_out;

	// Predicted controller state.
	logic [WORD_W-1:0] mode_w [NUM_MODE];
	logic [WORD_W-1:0] en_mask;
	logic [WORD_W-1:0] pend_bits;
	logic [WORD_W-1:0] deb_word;
	logic [WORD_W-1:0] last_lv;

	gpio_result_t exp_results [$];

	int  mismatches = 0;
	int  cycle_cnt  = 0;
	bit  send_idle  = 1'b1;
	bit  stall_en   = 1'b1;
	int  hold_req   = 0;
	int  hold_ack   = 0;
	int  hold_left  = 0;
	int  stall_left = 0;

	gpio_interrupt_controller_top #(
		.NUM_PINS(PINS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.reg_index (reg_index),
		.write_data(write_data),
		.pin_levels(pin_levels),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.read_data (read_data),
		.irq_out   (irq_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Update the predicted state with one accepted item and queue its result.
	function automatic void predict_irq_and_read(input logic [1:0] req,
			input logic [2:0] idx, input logic [WORD_W-1:0] data,
			input logic [WORD_W-1:0] pins);
		logic [WORD_W-1:0] hits;
		logic [WORD_W-1:0] clr;
		logic [3:0]        nib;
		logic              hit;
		gpio_result_t      res;
		hits = '0;
		clr  = '0;
		for (int p = 0; p < PINS; p++) begin
			nib = mode_w[p / 8][(p % 8) * 4 +: 4];
			case (nib)
				MODE_RISE: hit = !last_lv[p] && pins[p];
				MODE_FALL: hit = last_lv[p] && !pins[p];
				MODE_HIGH: hit = pins[p];
				MODE_LOW:  hit = !pins[p];
				MODE_BOTH: hit = last_lv[p] != pins[p];
				default:   hit = 1'b0;
			endcase
			hits[p] = hit && en_mask[p];
		end
		res.rd = '0;
		if (req == REQ_READ) begin
			case (idx)
				REG_MODE0, REG_MODE1, REG_MODE2, REG_MODE3: res.rd = mode_w[idx[1:0]];
				REG_ENABLE:   res.rd = en_mask;
				REG_PENDING:  res.rd = pend_bits;
				REG_DEBOUNCE: res.rd = deb_word;
				default:      res.rd = '0;
			endcase
		end
		if (req == REQ_WRITE) begin
			case (idx)
				REG_MODE0, REG_MODE1, REG_MODE2, REG_MODE3: mode_w[idx[1:0]] = data;
				REG_ENABLE:   en_mask = data;
				REG_PENDING:  clr = data;
				REG_DEBOUNCE: deb_word = data;
				default:      ;
			endcase
		end
		pend_bits = (pend_bits & ~clr) | hits;
		last_lv   = pins;
		res.irq   = |(pend_bits & en_mask);
		exp_results.push_back(res);
	endfunction

	// Offer one item, with an optional idle burst first, and wait for it to be taken.
	task automatic send_item(input logic [1:0] req, input logic [2:0] idx,
			input logic [WORD_W-1:0] data, input logic [WORD_W-1:0] pins);
		if (send_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		reg_index  <= idx;
		write_data <= data;
		pin_levels <= pins;
		do @(posedge clk); while (in_stall);
		predict_irq_and_read(req, idx, data, pins);
	endtask

	// A mode word whose nibbles are mostly real modes and sometimes unused codes.
	function automatic logic [WORD_W-1:0] rand_mode_word();
		logic [WORD_W-1:0] w;
		for (int k = 0; k < 8; k++)
			w[k * 4 +: 4] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(5, 15))
				: 4'($urandom_range(0, 4));
		return w;
	endfunction

	// Pin levels that mostly toggle a bit or two so that edges stay sparse.
	function automatic logic [WORD_W-1:0] rand_pins();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0:       return $urandom;
			1:       return '0;
			2:       return '1;
			3:       return last_lv ^ (32'h1 << $urandom_range(0, 31))
				^ (32'h1 << $urandom_range(0, 31));
			default: return last_lv ^ (32'h1 << $urandom_range(0, 31));
		endcase
	endfunction

	// One random item: mostly plain samples, reads and register writes.
	task automatic send_random_item();
		logic [1:0]        req;
		logic [2:0]        idx;
		logic [WORD_W-1:0] data;
		int                r;
		r    = $urandom_range(0, 99);
		req  = (r < 40) ? REQ_NONE : (r < 62) ? REQ_READ : (r < 95) ? REQ_WRITE : REQ_UNUSED;
		idx  = 3'($urandom_range(0, 7));
		data = $urandom;
		if (req == REQ_WRITE && idx <= REG_MODE3)
			data = rand_mode_word();
		else if (req == REQ_WRITE && idx == REG_ENABLE && $urandom_range(0, 2) == 0)
			data = '1;
		send_item(req, idx, data, rand_pins());
	endtask

	// Output side: random stall bursts plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack  = hold_req;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (stall_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic void note_mismatch(input string field, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (mismatches < MAX_SHOWN)
			$display("Mismatch on %s: expected %h, got %h", field, want, got);
		mismatches++;
	endfunction

	// Compare every taken result item with the oldest prediction.
	always @(posedge clk) begin
		gpio_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (exp_results.size() == 0) begin
				if (mismatches < MAX_SHOWN)
					$display("Result item with no expectation: read_data %h irq %b",
						read_data, irq_out);
				mismatches++;
			end else begin
				want = exp_results.pop_front();
				if (read_data !== want.rd)
					note_mismatch("read_data", want.rd, read_data);
				if (irq_out !== want.irq)
					note_mismatch("irq_out", WORD_W'(want.irq), WORD_W'(irq_out));
			end
		end
	end

	// Hang guard.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYC_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Every register reads as zero after reset, the unused index included.
	task automatic test_reset_state();
		for (int i = 0; i < 8; i++)
			send_item(REQ_READ, 3'(i), '0, '0);
	endtask

	// Write the mode, debounce and enable registers with extreme and mixed values and read back debounce and mode0.
	task automatic test_registers();
		send_item(REQ_WRITE, REG_MODE0, 32'h0F54_3210, '0);
		send_item(REQ_WRITE, REG_MODE1, '1, '0);
		send_item(REQ_WRITE, REG_MODE2, '1, '0);
		send_item(REQ_WRITE, REG_MODE3, 32'h2FFF_FFFF, '0);
		send_item(REQ_WRITE, REG_DEBOUNCE, 32'hA5A5_5A5A, '0);
		send_item(REQ_READ, REG_DEBOUNCE, '0, '0);
		send_item(REQ_READ, REG_MODE0, '0, '0);
		send_item(REQ_WRITE, REG_ENABLE, '1, '0);
	endtask

	// Rise, fall, both edges and the level modes, with pin 31 at the top.
	task automatic test_modes();
		send_item(REQ_NONE, REG_MODE0, '0, 32'h8000_001F);
		send_item(REQ_READ, REG_PENDING, '0, 32'h8000_001F);
		send_item(REQ_NONE, REG_MODE0, '0, '1);
		send_item(REQ_READ, REG_PENDING, '0, '0);
	endtask

	// A pending bit detected in the same item as its clear stays set.
	task automatic test_clear_race();
		send_item(REQ_WRITE, REG_PENDING, '1, '0);
		send_item(REQ_READ, REG_PENDING, '0, '1);
		send_item(REQ_WRITE, REG_ENABLE, '0, '1);
		send_item(REQ_READ, REG_PENDING, '0, '1);
	endtask

	// Writes to the unused index are dropped; the unused request acts as no access.
	task automatic test_unused_codes();
		send_item(REQ_WRITE, REG_UNUSED, '1, '1);
		send_item(REQ_READ, REG_UNUSED, '0, '0);
		send_item(REQ_UNUSED, REG_DEBOUNCE, '1, '1);
	endtask

	// Hold the output for a long stretch while the input keeps offering items.
	task automatic test_backpressure();
		send_idle = 1'b0;
		send_item(REQ_WRITE, REG_ENABLE, '1, last_lv);
		hold_req <= hold_req + 1;
		repeat (30) send_random_item();
		send_idle = 1'b1;
	endtask

	task automatic test_random(input int n_items);
		repeat (n_items) send_random_item();
	endtask

	// Full rate on both sides for the last part of the run.
	task automatic test_full_rate(input int n_items);
		send_idle = 1'b0;
		stall_en <= 1'b0;
		repeat (n_items) send_random_item();
	endtask

	initial begin
		for (int i = 0; i < NUM_MODE; i++)
			mode_w[i] = '0;
		en_mask   = '0;
		pend_bits = '0;
		deb_word  = '0;
		last_lv   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_registers();
		test_modes();
		test_clear_race();
		test_unused_codes();
		test_backpressure();
		test_random(740);
		test_full_rate(120);

		in_valid <= 1'b0;
		while (exp_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
